// ===== rtl/core/bsa_pkg.sv =====
// Shared types and constants for the bitmap slot allocator.
// Holds the transaction payload structs, request codes and the
// controller/datapath command and status structs. No dependencies.
package bsa_pkg;

    // Request codes carried in req_type.
    localparam logic [2:0] OP_ALLOC     = 3'd0;
    localparam logic [2:0] OP_SET       = 3'd1;
    localparam logic [2:0] OP_CLEAR     = 3'd2;
    localparam logic [2:0] OP_TEST      = 3'd3;
    localparam logic [2:0] OP_CLEAR_ALL = 3'd4;

    // Number of bits that an 8-bit index can name.
    localparam int INDEX_REACH = 256;

    typedef struct packed {
        logic [2:0] req_type;
        logic [7:0] bit_index;
    } req_t;

    typedef struct packed {
        logic [7:0] found_index;
        logic       found;
        logic       bit_value;
        logic       range_error;
    } rsp_t;

    typedef struct packed {
        logic capture;    // latch an accepted request, read its word
        logic scan_step;  // evaluate one word of an allocate scan
        logic mod_step;   // set, clear or test one bit
        logic clr_step;   // write zero to one word of the sweep
        logic res_plain;  // result with only the range flag
        logic load_out;   // move the result into the output register
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       range_err;
        logic       scan_hit;
        logic       scan_last;
        logic       clr_last;
    } sts_t;

endpackage

// ===== rtl/core/bsa_dp.sv =====
// Datapath of the bitmap slot allocator: bitmap memory, scan logic,
// clear sweep counter and result registers. Depends on bsa_pkg.
module bsa_dp #(
    parameter int NUM_WORDS = 32,
    parameter int WORD_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  bsa_pkg::req_t req,
    input  bsa_pkg::cmd_t cmd,
    output bsa_pkg::sts_t sts,
    output bsa_pkg::rsp_t rsp
);

    localparam int WORD_AW     = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int BIT_AW      = $clog2(WORD_BITS);
    localparam int TOTAL_BITS  = NUM_WORDS * WORD_BITS;
    localparam int LIMIT       = (TOTAL_BITS < bsa_pkg::INDEX_REACH) ?
                                 TOTAL_BITS : bsa_pkg::INDEX_REACH;
    localparam int REACH_WORDS = (bsa_pkg::INDEX_REACH + WORD_BITS - 1) / WORD_BITS;
    localparam int LAST_WORD   = ((NUM_WORDS < REACH_WORDS) ? NUM_WORDS : REACH_WORDS) - 1;

    logic [WORD_BITS-1:0] mem [NUM_WORDS];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [WORD_AW-1:0]   raddr;
    logic [WORD_AW-1:0]   waddr;
    logic [WORD_BITS-1:0] wdata;
    logic                 we;

    logic [WORD_AW-1:0]   word_tab [bsa_pkg::INDEX_REACH];
    logic [BIT_AW-1:0]    bit_tab  [bsa_pkg::INDEX_REACH];

    bsa_pkg::req_t        req_reg;
    logic [WORD_AW-1:0]   cur_reg;
    logic [7:0]           base_reg;
    logic [WORD_AW-1:0]   clr_cnt_reg;
    logic [WORD_AW-1:0]   clr_cnt_next;
    bsa_pkg::rsp_t        res_reg;
    bsa_pkg::rsp_t        out_reg;

    logic [WORD_BITS-1:0] free_bits;
    logic [BIT_AW-1:0]    sel;
    logic                 hit;
    logic                 last;
    logic [BIT_AW-1:0]    pos_in_word;
    logic [WORD_BITS-1:0] bmask;
    logic                 range_err;
    logic                 advance;

    // Constant lookup tables that split an 8-bit index into word and bit.
    for (genvar k = 0; k < bsa_pkg::INDEX_REACH; k++) begin : g_tab
        assign word_tab[k] = WORD_AW'(k / WORD_BITS);
        assign bit_tab[k]  = BIT_AW'(k % WORD_BITS);
    end

    // Bits of the current word that lie at or after the start index and
    // below the addressable limit, and are still zero.
    always_comb
    begin
        logic [9:0] pos;
        for (int j = 0; j < WORD_BITS; j++)
        begin
            pos = {2'b00, base_reg} + 10'(j);
            free_bits[j] = (pos >= {2'b00, req_reg.bit_index}) && (pos < 10'(LIMIT))
                           && !rd_data_reg[j];
        end
    end

    always_comb
    begin
        sel = '0;
        for (int j = WORD_BITS - 1; j >= 0; j--)
        begin
            if (free_bits[j])
            begin
                sel = BIT_AW'(j);
            end
        end
    end

    assign hit         = |free_bits;
    assign last        = (cur_reg == WORD_AW'(LAST_WORD));
    assign advance     = cmd.scan_step && !hit && !last;
    assign pos_in_word = bit_tab[req_reg.bit_index];
    assign bmask       = WORD_BITS'(1) << pos_in_word;
    assign range_err   = (req_reg.req_type <= bsa_pkg::OP_TEST)
                         && ({1'b0, req_reg.bit_index} >= 9'(LIMIT));

    always_comb
    begin
        if (cmd.capture)
        begin
            raddr = word_tab[req.bit_index];
        end
        else
        begin
            raddr = cur_reg + WORD_AW'(1);
        end
    end

    always_comb
    begin
        we    = 1'b0;
        waddr = cur_reg;
        wdata = rd_data_reg;
        if (cmd.clr_step)
        begin
            we    = 1'b1;
            waddr = clr_cnt_reg;
            wdata = '0;
        end
        else if (cmd.scan_step && hit)
        begin
            we    = 1'b1;
            wdata = rd_data_reg | (WORD_BITS'(1) << sel);
        end
        else if (cmd.mod_step && req_reg.req_type == bsa_pkg::OP_SET)
        begin
            we    = 1'b1;
            wdata = rd_data_reg | bmask;
        end
        else if (cmd.mod_step && req_reg.req_type == bsa_pkg::OP_CLEAR)
        begin
            we    = 1'b1;
            wdata = rd_data_reg & ~bmask;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rd_data_reg <= mem[raddr];
    end

    assign clr_cnt_next = (clr_cnt_reg == WORD_AW'(NUM_WORDS - 1)) ?
                          '0 : clr_cnt_reg + WORD_AW'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.clr_step)
        begin
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            req_reg  <= req;
            cur_reg  <= word_tab[req.bit_index];
            base_reg <= req.bit_index - 8'(bit_tab[req.bit_index]);
        end
        else if (advance)
        begin
            cur_reg  <= cur_reg + WORD_AW'(1);
            base_reg <= base_reg + 8'(WORD_BITS);
        end

        if (cmd.scan_step && (hit || last))
        begin
            res_reg <= '{found_index: (hit ? base_reg + 8'(sel) : 8'd0),
                         found:       hit,
                         bit_value:   1'b0,
                         range_error: 1'b0};
        end
        else if (cmd.mod_step)
        begin
            res_reg <= '{found_index: 8'd0,
                         found:       1'b0,
                         bit_value:   (req_reg.req_type == bsa_pkg::OP_TEST) &&
                                      |(rd_data_reg & bmask),
                         range_error: 1'b0};
        end
        else if (cmd.res_plain)
        begin
            res_reg <= '{found_index: 8'd0,
                         found:       1'b0,
                         bit_value:   1'b0,
                         range_error: range_err};
        end

        if (cmd.load_out)
        begin
            out_reg <= res_reg;
        end
    end

    assign sts.op        = req_reg.req_type;
    assign sts.range_err = range_err;
    assign sts.scan_hit  = hit;
    assign sts.scan_last = last;
    assign sts.clr_last  = (clr_cnt_reg == WORD_AW'(NUM_WORDS - 1));
    assign rsp           = out_reg;

endmodule

// ===== rtl/core/bsa_ctrl.sv =====
// Controller of the bitmap slot allocator: sequences the reset sweep,
// request execution and result hand-off. Depends on bsa_pkg.
module bsa_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    input  bsa_pkg::sts_t sts,
    output bsa_pkg::cmd_t cmd
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_SCAN = 3'd3;
    localparam logic [2:0] S_WIPE = 3'd4;
    localparam logic [2:0] S_DONE = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       rsp_valid_reg;
    logic       rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;
    assign req_ready = (state_reg == S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.range_err)
                begin
                    cmd.res_plain = 1'b1;
                    state_next    = S_DONE;
                end
                else
                begin
                    unique case (sts.op) inside
                        bsa_pkg::OP_ALLOC:
                        begin
                            cmd.scan_step = 1'b1;
                            state_next    = (sts.scan_hit || sts.scan_last) ? S_DONE : S_SCAN;
                        end
                        bsa_pkg::OP_SET, bsa_pkg::OP_CLEAR, bsa_pkg::OP_TEST:
                        begin
                            cmd.mod_step = 1'b1;
                            state_next   = S_DONE;
                        end
                        bsa_pkg::OP_CLEAR_ALL:
                        begin
                            state_next = S_WIPE;
                        end
                        default:
                        begin
                            cmd.res_plain = 1'b1;
                            state_next    = S_DONE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (sts.scan_hit || sts.scan_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_WIPE:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.res_plain = 1'b1;
                    state_next    = S_DONE;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.load_out)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        else
        begin
            rsp_valid_next = rsp_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

`ifndef ASSERT_OFF
    // The bitmap is never written while a new transaction may be taken.
    a_no_write_in_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !(cmd.clr_step || cmd.scan_step || cmd.mod_step))
        else $error("bitmap write issued while idle");

    // An accepted request always starts execution in the next cycle.
    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && req_ready) |=> (state_reg == S_EXEC))
        else $error("accepted request did not start execution");

    // A result never overwrites one that the receiver has not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!rsp_valid_reg || rsp_ready))
        else $error("pending result overwritten");
`endif

endmodule

// ===== rtl/core/bitmap_slot_allocator.sv =====
// Top level of the bitmap slot allocator: joins controller and datapath.
// Depends on bsa_pkg, bsa_ctrl and bsa_dp.
//
// Usage. Requests arrive on the req channel (req_valid, req_ready, req_data)
// and each one produces exactly one result transaction on the rsp channel
// (rsp_valid, rsp_ready, rsp_data). A request allocates the first free bit at
// or after bit_index, sets, clears or tests one bit, or clears the whole map.
// Only bits below 256 and below NUM_WORDS*WORD_BITS are reachable.
//
// Timing. Requests are handled one at a time. For set, clear, test, unused
// codes and out-of-range indexes the result is formed in the execute state,
// and rsp_valid rises when it moves on from the done state into the output
// register. An allocate scans one bitmap word per cycle through the single
// memory read port, until it finds a free bit or reaches the last reachable
// word. Clear-all sweeps the memory one word per cycle. A new request is
// accepted in the cycle after the previous result enters the output register.
//
// Reset. After rst_n is released the block runs a clearing pass over all
// NUM_WORDS words to zero the bitmap; req_ready stays low during that pass.
//
// Stalls. The output register holds a finished result while rsp_ready is low,
// and the next request may be accepted and executed meanwhile; its result
// then waits internally until the output register is free.
module bitmap_slot_allocator #(
    parameter int NUM_WORDS = 32,
    parameter int WORD_BITS = 8
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  bsa_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output bsa_pkg::rsp_t rsp_data
);

    // Command and status between the sequencer and the datapath.
    bsa_pkg::cmd_t cmd;
    bsa_pkg::sts_t sts;

    // The controller owns both handshakes; the datapath owns all payload.
    bsa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // The datapath keeps the bitmap in a one-read, one-write memory.
    bsa_dp #(
        .NUM_WORDS (NUM_WORDS),
        .WORD_BITS (WORD_BITS)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_data),
        .cmd   (cmd),
        .sts   (sts),
        .rsp   (rsp_data)
    );

endmodule
